// ===== rtl/core/ordered_record_table_unit_defines.svh =====
// Assertion macros for the ordered record table unit.
`ifndef ORDERED_RECORD_TABLE_UNIT_DEFINES_SVH
`define ORDERED_RECORD_TABLE_UNIT_DEFINES_SVH
`ifndef SYNTHESIS
`define ORT_ASSERT(label, clk, rst, prop, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);
`define ORT_ASSERT_NORST(label, clk, prop, msg) \
   label: assert property (@(posedge clk) (prop)) else $error(msg);
`else
`define ORT_ASSERT(label, clk, rst, prop, msg)
`define ORT_ASSERT_NORST(label, clk, prop, msg)
`endif
`endif

// ===== rtl/core/ort_pkg.sv =====
// Package: types, codes and text cleanup for the ordered record table unit.
package ort_pkg;
   localparam int CapacityDefault  = 64;
   localparam int NameBytesDefault = 8;
   localparam int SexBytesDefault  = 4;

   typedef enum logic [2:0] {
      REQ_PUSH_BACK  = 3'd0,
      REQ_PUSH_FRONT = 3'd1,
      REQ_INSERT     = 3'd2,
      REQ_POP_BACK   = 3'd3,
      REQ_POP_FRONT  = 3'd4,
      REQ_ERASE      = 3'd5,
      REQ_SEARCH     = 3'd6,
      REQ_MODIFY     = 3'd7
   } req_code_type;

   typedef enum logic [2:0] {
      ST_OK       = 3'd0,
      ST_FULL     = 3'd1,
      ST_EMPTY    = 3'd2,
      ST_BADPOS   = 3'd3,
      ST_NOTFOUND = 3'd4
   } status_type;

   typedef enum logic [2:0] {
      S_IDLE, S_UP_RD, S_UP_WR, S_DN_RD, S_DN_WR, S_SR_RD, S_SR_CMP, S_DONE
   } state_type;

   typedef struct packed {
      logic [2:0]  req_type;
      logic [6:0]  position;
      logic [7:0]  entry_age;
      logic [63:0] entry_name;
      logic [31:0] entry_sex;
      logic [63:0] key_name;
   } req_type_type;

   typedef struct packed {
      logic [2:0]  status;
      logic [5:0]  found_index;
      logic [7:0]  found_age;
      logic [63:0] found_name;
      logic [31:0] found_sex;
      logic [6:0]  record_count;
   } rsp_type;

   function automatic logic [63:0] clean_text(input logic [63:0] v, input int nbytes);
      logic [63:0] r;
      logic        stop;
      r = '0;
      stop = 1'b0;
      for (int k = 0; k < 8; k++) begin
         if (k >= nbytes || v[8*k +: 8] == 8'd0) stop = 1'b1;
         if (!stop) r[8*k +: 8] = v[8*k +: 8];
      end
      return r;
   endfunction
endpackage

// ===== rtl/core/ordered_record_table_unit.sv =====
// Top level: ordered record table with a sequenced shift and search walk.
// One request is taken while busy is low; its result shows on rsp_valid for one cycle and
// cannot be stalled. Busy drops in the cycle that shows the result, so the next request
// can be taken at its closing edge. A rejected request goes straight to its result; an
// accepted push, insert, pop or erase moves records one at a time through the single-port
// record memory, each with a read state and a write state (insert and front operations
// move the records at and above the position; back push and pop move none); search and
// modify read and compare one record at a time, walking from index 0 to the first match.
`include "ordered_record_table_unit_defines.svh"
module ordered_record_table_unit import ort_pkg::*; #(
   parameter int CAPACITY   = CapacityDefault,
   parameter int NAME_BYTES = NameBytesDefault,
   parameter int SEX_BYTES  = SexBytesDefault
) (
   input  logic         clock,
   input  logic         reset,
   input  logic         start,
   output logic         busy,
   input  req_type_type req_item,
   output logic         rsp_valid,
   output rsp_type      rsp_item
);
   localparam int AW = $clog2(CAPACITY);
   localparam int CW = $clog2(CAPACITY + 1);
   localparam int RW = 8 + 64 + 32;

   logic [RW-1:0] mem [CAPACITY];

   state_type     state_ff, state_in;
   logic [CW-1:0] count_ff, count_in;
   logic [CW-1:0] idx_ff, idx_in;
   logic [CW-1:0] stop_ff, stop_in;
   req_type_type  req_ff, req_in;
   rsp_type       rsp_ff, rsp_in;
   logic          rv_ff, rv_in;
   logic [RW-1:0] rd_ff;
   logic          rd_en, wr_en;
   logic [AW-1:0] rd_addr, wr_addr;
   logic [RW-1:0] wr_data, new_rec;
   logic [63:0]   c_name, c_key;
   logic [63:0]   c_sex_full;
   logic [31:0]   c_sex;

   assign c_name     = clean_text(req_item.entry_name, NAME_BYTES);
   assign c_key      = clean_text(req_item.key_name, NAME_BYTES);
   assign c_sex_full = clean_text({32'd0, req_item.entry_sex}, (SEX_BYTES > 4) ? 4 : SEX_BYTES);
   assign c_sex      = c_sex_full[31:0];
   assign new_rec = {req_ff.entry_age, req_ff.entry_name, req_ff.entry_sex};

   always_ff @(posedge clock) begin
      if (wr_en) mem[wr_addr] <= wr_data;
      if (rd_en) rd_ff <= mem[rd_addr];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         count_ff <= '0;
         rv_ff    <= 1'b0;
      end else begin
         state_ff <= state_in;
         count_ff <= count_in;
         rv_ff    <= rv_in;
      end
      idx_ff  <= idx_in;
      stop_ff <= stop_in;
      req_ff  <= req_in;
      rsp_ff  <= rsp_in;
   end

   always_comb begin
      state_in = state_ff;
      count_in = count_ff;
      idx_in   = idx_ff;
      stop_in  = stop_ff;
      req_in   = req_ff;
      rsp_in   = rsp_ff;
      rv_in    = 1'b0;
      rd_en    = 1'b0;
      wr_en    = 1'b0;
      rd_addr  = idx_ff[AW-1:0];
      wr_addr  = idx_ff[AW-1:0];
      wr_data  = rd_ff;
      unique case (state_ff)
         S_IDLE: begin
            if (start) begin
               req_in = req_item;
               req_in.entry_name = c_name;
               req_in.entry_sex  = c_sex;
               req_in.key_name   = c_key;
               rsp_in = '0;
               rsp_in.status = ST_OK;
               state_in = S_DONE;
               unique case (req_code_type'(req_item.req_type))
                  REQ_PUSH_BACK, REQ_PUSH_FRONT, REQ_INSERT: begin
                     if (req_code_type'(req_item.req_type) == REQ_INSERT &&
                         req_item.position > 7'(count_ff))
                        rsp_in.status = ST_BADPOS;
                     else if (count_ff >= CW'(CAPACITY))
                        rsp_in.status = ST_FULL;
                     else begin
                        idx_in  = count_ff;
                        stop_in = (req_code_type'(req_item.req_type) == REQ_PUSH_BACK)
                                  ? count_ff
                                  : (req_code_type'(req_item.req_type) == REQ_PUSH_FRONT)
                                  ? '0 : CW'(req_item.position);
                        state_in = S_UP_RD;
                     end
                  end
                  REQ_POP_BACK, REQ_POP_FRONT, REQ_ERASE: begin
                     if (count_ff == '0)
                        rsp_in.status = ST_EMPTY;
                     else if (req_code_type'(req_item.req_type) == REQ_ERASE &&
                              req_item.position >= 7'(count_ff))
                        rsp_in.status = ST_BADPOS;
                     else begin
                        idx_in = (req_code_type'(req_item.req_type) == REQ_POP_BACK)
                                 ? count_ff - CW'(1)
                                 : (req_code_type'(req_item.req_type) == REQ_POP_FRONT)
                                 ? '0 : CW'(req_item.position);
                        state_in = S_DN_RD;
                     end
                  end
                  REQ_SEARCH, REQ_MODIFY: begin
                     idx_in = '0;
                     if (count_ff == '0) rsp_in.status = ST_NOTFOUND;
                     else state_in = S_SR_RD;
                  end
               endcase
            end
         end
         S_UP_RD: begin
            if (idx_ff == stop_ff) begin
               wr_en   = 1'b1;
               wr_data = new_rec;
               count_in = count_ff + CW'(1);
               state_in = S_DONE;
            end else begin
               rd_en   = 1'b1;
               rd_addr = AW'(idx_ff - CW'(1));
               state_in = S_UP_WR;
            end
         end
         S_UP_WR: begin
            wr_en  = 1'b1;
            idx_in = idx_ff - CW'(1);
            state_in = S_UP_RD;
         end
         S_DN_RD: begin
            if (idx_ff + CW'(1) >= count_ff) begin
               count_in = count_ff - CW'(1);
               state_in = S_DONE;
            end else begin
               rd_en   = 1'b1;
               rd_addr = AW'(idx_ff + CW'(1));
               state_in = S_DN_WR;
            end
         end
         S_DN_WR: begin
            wr_en  = 1'b1;
            idx_in = idx_ff + CW'(1);
            state_in = S_DN_RD;
         end
         S_SR_RD: begin
            rd_en = 1'b1;
            state_in = S_SR_CMP;
         end
         S_SR_CMP: begin
            if (rd_ff[95:32] == req_ff.key_name) begin
               rsp_in.found_index = 6'(idx_ff);
               rsp_in.found_age   = rd_ff[103:96];
               rsp_in.found_name  = rd_ff[95:32];
               rsp_in.found_sex   = rd_ff[31:0];
               if (req_code_type'(req_ff.req_type) == REQ_MODIFY) begin
                  wr_en   = 1'b1;
                  wr_data = new_rec;
               end
               state_in = S_DONE;
            end else if (idx_ff + CW'(1) >= count_ff) begin
               rsp_in.status = ST_NOTFOUND;
               state_in = S_DONE;
            end else begin
               idx_in = idx_ff + CW'(1);
               state_in = S_SR_RD;
            end
         end
         S_DONE: begin
            rsp_in.record_count = 7'(count_ff);
            rv_in = 1'b1;
            state_in = S_IDLE;
         end
         default: state_in = S_IDLE;
      endcase
   end

   assign busy      = (state_ff != S_IDLE);
   assign rsp_valid = rv_ff;
   assign rsp_item  = rsp_ff;

   `ORT_ASSERT(a_count_cap, clock, reset, count_ff <= CW'(CAPACITY), "count above capacity")
   `ORT_ASSERT(a_rsp_one, clock, reset, rv_ff |=> !rv_ff, "result held two cycles")
   `ORT_ASSERT(a_done_rsp, clock, reset, (state_ff == S_DONE) |=> rv_ff, "done without result")
   `ORT_ASSERT(a_busy_start, clock, reset, (start && !busy) |=> busy, "start not taken")
endmodule

// ===== verif/testbench.sv =====
// Testbench for the ordered record table unit: directed table plus random requests.
module testbench;
   import ort_pkg::*;

   localparam int Cap = 64;
   localparam int RandItems = 1770;
   localparam longint CycleLimit = 2000000;

   logic         clock = 1'b0;
   logic         reset = 1'b1;
   logic         start = 1'b0;
   logic         busy;
   req_type_type req_item = '0;
   logic         rsp_valid;
   rsp_type      rsp_item;

   ordered_record_table_unit uut (
      .clock(clock), .reset(reset), .start(start), .busy(busy),
      .req_item(req_item), .rsp_valid(rsp_valid), .rsp_item(rsp_item)
   );

   always #6 clock = ~clock;

   // mirror of the table
   logic [7:0]  mir_age [Cap];
   logic [63:0] mir_name [Cap];
   logic [31:0] mir_sex [Cap];
   int          mir_count;
   rsp_type     pending_rsp [$];
   int          fail_count = 0;
   longint      cycle_count = 0;
   int          idle_pct = 0;
   logic [63:0] name_pool [8];

   function automatic logic [63:0] trim_text(logic [63:0] v, int nbytes);
      logic [63:0] r;
      r = '0;
      for (int k = 0; k < nbytes; k++) begin
         if (v[8*k +: 8] == 8'd0) break;
         r[8*k +: 8] = v[8*k +: 8];
      end
      return r;
   endfunction

   function automatic rsp_type table_step(req_type_type rq);
      rsp_type     r;
      logic [63:0] nm, key;
      logic [31:0] sx;
      int          pos, hit;
      r = '0;
      nm = trim_text(rq.entry_name, 8);
      sx = 32'(trim_text({32'd0, rq.entry_sex}, 4));
      key = trim_text(rq.key_name, 8);
      pos = rq.position;
      r.status = ST_OK;
      case (req_code_type'(rq.req_type))
         REQ_PUSH_BACK, REQ_PUSH_FRONT, REQ_INSERT: begin
            if (rq.req_type == REQ_PUSH_BACK) pos = mir_count;
            else if (rq.req_type == REQ_PUSH_FRONT) pos = 0;
            if (pos > mir_count) r.status = ST_BADPOS;
            else if (mir_count >= Cap) r.status = ST_FULL;
            else begin
               for (int i = mir_count; i > pos; i--) begin
                  mir_age[i] = mir_age[i-1];
                  mir_name[i] = mir_name[i-1];
                  mir_sex[i] = mir_sex[i-1];
               end
               mir_age[pos] = rq.entry_age;
               mir_name[pos] = nm;
               mir_sex[pos] = sx;
               mir_count++;
            end
         end
         REQ_POP_BACK, REQ_POP_FRONT, REQ_ERASE: begin
            if (rq.req_type == REQ_POP_BACK) pos = mir_count - 1;
            else if (rq.req_type == REQ_POP_FRONT) pos = 0;
            if (mir_count == 0) r.status = ST_EMPTY;
            else if (pos >= mir_count) r.status = ST_BADPOS;
            else begin
               for (int i = pos; i + 1 < mir_count; i++) begin
                  mir_age[i] = mir_age[i+1];
                  mir_name[i] = mir_name[i+1];
                  mir_sex[i] = mir_sex[i+1];
               end
               mir_count--;
            end
         end
         default: begin
            hit = -1;
            for (int i = 0; i < mir_count; i++)
               if (hit < 0 && mir_name[i] == key) hit = i;
            if (hit < 0) r.status = ST_NOTFOUND;
            else begin
               r.found_index = 6'(hit);
               r.found_age = mir_age[hit];
               r.found_name = mir_name[hit];
               r.found_sex = mir_sex[hit];
               if (rq.req_type == REQ_MODIFY) begin
                  mir_age[hit] = rq.entry_age;
                  mir_name[hit] = nm;
                  mir_sex[hit] = sx;
               end
            end
         end
      endcase
      r.record_count = 7'(mir_count);
      return r;
   endfunction

   task automatic issue_item(req_type_type rq);
      while ($urandom_range(99) < idle_pct) @(negedge clock);
      while (busy) @(negedge clock);
      start <= 1'b1;
      req_item <= rq;
      @(posedge clock);
      pending_rsp.push_back(table_step(rq));
      @(negedge clock);
      start <= 1'b0;
   endtask

   // directed row with optional hand-typed expected status and count
   task automatic issue_typed(req_code_type op, int pos, logic [63:0] nm, logic [63:0] key,
                              int want_status, int want_count);
      req_type_type rq;
      rsp_type      r;
      rq = '0;
      rq.req_type = op;
      rq.position = 7'(pos);
      rq.entry_age = 8'($urandom);
      rq.entry_name = nm;
      rq.entry_sex = $urandom;
      rq.key_name = key;
      issue_item(rq);
      r = pending_rsp[$];
      if (want_status >= 0 && (r.status != want_status || r.record_count != want_count)) begin
         $error("directed row: status exp %0d got %0d, count exp %0d got %0d",
                want_status, r.status, want_count, r.record_count);
         fail_count++;
      end
   endtask

   function automatic logic [63:0] random_name();
      logic [63:0] v;
      case ($urandom_range(3))
         0: v = {$urandom, $urandom};
         1: v = 64'd0;
         default: v = name_pool[$urandom_range(7)];
      endcase
      return v;
   endfunction

   task automatic random_item();
      req_type_type rq;
      int           fill_bias;
      rq = '0;
      fill_bias = $urandom_range(99);
      if (mir_count < 8 && fill_bias < 50) rq.req_type = 3'($urandom_range(2));
      else if (mir_count > 56 && fill_bias < 50) rq.req_type = 3'(3 + $urandom_range(2));
      else rq.req_type = 3'($urandom);
      rq.position = ($urandom_range(9) == 0) ? 7'($urandom_range(127))
                                             : 7'($urandom_range(mir_count + 1));
      rq.entry_age = 8'($urandom);
      rq.entry_name = random_name();
      rq.entry_sex = $urandom;
      rq.key_name = random_name();
      issue_item(rq);
   endtask

   always @(posedge clock) begin
      rsp_type e;
      cycle_count <= cycle_count + 1;
      if (cycle_count > CycleLimit) begin
         $display("TEST FAILED");
         $finish;
      end
      if (!reset && rsp_valid) begin
         if (pending_rsp.size() == 0) begin
            $error("result with none expected");
            fail_count++;
         end else begin
            e = pending_rsp.pop_front();
            if (rsp_item.status != e.status) begin
               $error("status exp %0d got %0d", e.status, rsp_item.status);
               fail_count++;
            end
            if (rsp_item.found_index != e.found_index) begin
               $error("found_index exp %0d got %0d", e.found_index, rsp_item.found_index);
               fail_count++;
            end
            if (rsp_item.found_age != e.found_age) begin
               $error("found_age exp %0d got %0d", e.found_age, rsp_item.found_age);
               fail_count++;
            end
            if (rsp_item.found_name != e.found_name) begin
               $error("found_name exp %h got %h", e.found_name, rsp_item.found_name);
               fail_count++;
            end
            if (rsp_item.found_sex != e.found_sex) begin
               $error("found_sex exp %h got %h", e.found_sex, rsp_item.found_sex);
               fail_count++;
            end
            if (rsp_item.record_count != e.record_count) begin
               $error("record_count exp %0d got %0d", e.record_count, rsp_item.record_count);
               fail_count++;
            end
         end
      end
   end

   initial begin
      int waited;
      mir_count = 0;
      for (int i = 0; i < 8; i++)
         name_pool[i] = (i == 0) ? 64'hFFFF_FFFF_FFFF_FFFF : {$urandom, $urandom};
      name_pool[1] = 64'h0000_0000_0000_0041;
      name_pool[2] = 64'h4200_0000_0000_0041;
      repeat (2) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      // directed part
      issue_typed(REQ_POP_BACK, 0, 0, 0, ST_EMPTY, 0);
      issue_typed(REQ_POP_FRONT, 0, 0, 0, ST_EMPTY, 0);
      issue_typed(REQ_ERASE, 0, 0, 0, ST_EMPTY, 0);
      issue_typed(REQ_SEARCH, 0, 0, 0, ST_NOTFOUND, 0);
      issue_typed(REQ_MODIFY, 0, 0, 0, ST_NOTFOUND, 0);
      issue_typed(REQ_INSERT, 1, 1, 0, ST_BADPOS, 0);
      issue_typed(REQ_INSERT, 127, 1, 0, ST_BADPOS, 0);
      issue_typed(REQ_PUSH_BACK, 0, 64'hFFFF_FFFF_FFFF_FFFF, 0, ST_OK, 1);
      issue_typed(REQ_PUSH_FRONT, 0, 64'h0000_0000_0000_0041, 0, ST_OK, 2);
      issue_typed(REQ_INSERT, 1, 64'h4200_0000_0000_0041, 0, ST_OK, 3);
      issue_typed(REQ_SEARCH, 0, 0, 64'h0000_0000_0000_0041, -1, 0);
      issue_typed(REQ_MODIFY, 0, 0, 64'hFFFF_FFFF_FFFF_FFFF, -1, 0);
      issue_typed(REQ_SEARCH, 0, 0, 64'h0000_0000_0000_0000, -1, 0);
      issue_typed(REQ_ERASE, 3, 0, 0, ST_BADPOS, 3);
      issue_typed(REQ_ERASE, 1, 0, 0, ST_OK, 2);
      while (mir_count < Cap) issue_typed(REQ_PUSH_BACK, 0, {$urandom, $urandom}, 0, -1, 0);
      issue_typed(REQ_PUSH_BACK, 0, 0, 0, ST_FULL, 64);
      issue_typed(REQ_PUSH_FRONT, 0, 0, 0, ST_FULL, 64);
      issue_typed(REQ_INSERT, 64, 0, 0, ST_FULL, 64);
      issue_typed(REQ_INSERT, 65, 0, 0, ST_BADPOS, 64);
      issue_typed(REQ_ERASE, 63, 0, 0, ST_OK, 63);
      issue_typed(REQ_SEARCH, 0, 0, name_pool[1], -1, 0);
      // random part in idling phases
      for (int n = 0; n < RandItems; n++) begin
         case (n * 4 / RandItems)
            0: idle_pct = 0;
            1: idle_pct = 59;
            2: idle_pct = 0;
            default: idle_pct = 35;
         endcase
         random_item();
      end
      waited = 0;
      while (pending_rsp.size() != 0 && waited < 1000) begin
         @(posedge clock);
         waited++;
      end
      repeat (200) @(posedge clock);
      if (fail_count == 0 && pending_rsp.size() == 0)
         $display("TEST PASSED");
      else
         $display("TEST FAILED");
      $finish;
   end
endmodule
